/* src/cia_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg
// shared types and register codes for the dual timer interrupt block
// ----------------------------------------------------------------------------
package cia_pkg;

  // request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // register map
  localparam logic [3:0] ADDR_KEY_COL = 4'h0;
  localparam logic [3:0] ADDR_KEY_ROW = 4'h1;
  localparam logic [3:0] ADDR_TA_LO   = 4'h4;
  localparam logic [3:0] ADDR_TA_HI   = 4'h5;
  localparam logic [3:0] ADDR_TB_LO   = 4'h6;
  localparam logic [3:0] ADDR_TB_HI   = 4'h7;
  localparam logic [3:0] ADDR_ICR     = 4'hD;
  localparam logic [3:0] ADDR_CRA     = 4'hE;
  localparam logic [3:0] ADDR_CRB     = 4'hF;

  localparam int unsigned REG_DEPTH = 16;

  // control and interrupt register bits
  localparam int unsigned CR_START     = 0;
  localparam int unsigned CR_ONESHOT   = 3;
  localparam int unsigned CR_LOAD      = 4;
  localparam int unsigned ICR_SET_CLR  = 7;
  localparam logic [7:0]  ICR_READ_TAG = 8'h80;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] address;
    logic [7:0] write_data;
    logic [7:0] key_rows;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [7:0] key_column;
  } out_item_t;

  // per-timer strobes for one committed request
  typedef struct packed {
    logic       tick;
    logic       wr_lo;
    logic       wr_hi;
    logic       wr_ctrl;
    logic       wr_mask;
    logic [7:0] data;
  } timer_ctrl_t;

endpackage
`default_nettype wire

/* src/cia_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_timer
// one 16-bit down-counter with reload latch, mode bits and interrupt mask
// ----------------------------------------------------------------------------
module cia_timer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  commit,
  input  cia_pkg::timer_ctrl_t ctrl,
  output logic                 fire
);
  import cia_pkg::*;

  logic [15:0] latch_r, latch_nxt;
  logic [15:0] count_r, count_nxt;
  logic        run_r, run_nxt;
  logic        cont_r, cont_nxt;
  logic        mask_r, mask_nxt;
  logic [15:0] count_dec;

  assign count_dec = count_r - 16'd1;

  // underflow to zero with the interrupt unmasked
  assign fire = ctrl.tick && run_r && mask_r && (count_dec == 16'd0);

  // next state for one request
  always_comb begin
    latch_nxt = latch_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    cont_nxt  = cont_r;
    mask_nxt  = mask_r;
    if (ctrl.tick && run_r) begin
      count_nxt = count_dec;
      if (fire) begin
        if (cont_r) begin
          count_nxt = latch_r;
        end else begin
          run_nxt = 1'b0;
        end
      end
    end
    if (ctrl.wr_lo) begin
      latch_nxt[7:0] = ctrl.data;
    end
    if (ctrl.wr_hi) begin
      latch_nxt[15:8] = ctrl.data;
    end
    if (ctrl.wr_ctrl) begin
      run_nxt  = ctrl.data[CR_START];
      cont_nxt = !ctrl.data[CR_ONESHOT];
      if (ctrl.data[CR_LOAD]) begin
        count_nxt = latch_r;
      end
    end
    if (ctrl.wr_mask) begin
      mask_nxt = ctrl.data[ICR_SET_CLR];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
      count_r <= '0;
      run_r   <= 1'b0;
      cont_r  <= 1'b0;
      mask_r  <= 1'b0;
    end else if (commit) begin
      latch_r <= latch_nxt;
      count_r <= count_nxt;
      run_r   <= run_nxt;
      cont_r  <= cont_nxt;
      mask_r  <= mask_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/cia_dual_timer_interrupt_block.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_dual_timer_interrupt_block
// two-timer interrupt adapter with a small register file
// ----------------------------------------------------------------------------
// Usage: each request on in_data is a tick, a register read or a register
// write; every request gives exactly one response on out_data carrying the
// read byte (zero for ticks and writes), the interrupt line level after the
// request and the stored keyboard column byte.
// Both channels are valid/ready. A request lands in an input register, is
// worked in one pass of decrement/compare and register decode, and its
// response is loaded into the output register once that register is free.
// One request is taken every cycle as long as the response side keeps up,
// set by the single state update per cycle between the two registers.
// When out_ready is low the output register holds its response, the input
// register holds one more request and in_ready drops only when both are full.
// Synchronous active-low reset clears timers, latches, flags, the interrupt
// line, the register file and both stage valid bits.
// ----------------------------------------------------------------------------
module cia_dual_timer_interrupt_block (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  cia_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output cia_pkg::out_item_t out_data
);
  import cia_pkg::*;

  in_item_t    req_r;
  logic        req_valid_r;
  logic        advance;
  logic [7:0]  reg_file_r [REG_DEPTH];
  logic [1:0]  flags_r, flags_nxt;
  logic        irq_r, irq_nxt;
  logic [7:0]  rd_nxt;
  logic [7:0]  key_col_nxt;
  logic        is_tick, is_read, is_write;
  logic        fire_a, fire_b;
  timer_ctrl_t ctrl_a, ctrl_b;
  out_item_t   out_r;
  logic        out_valid_r;

  // handshake: the request moves on when the output register is free
  assign advance  = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_data;
    end
  end

  // request decode
  assign is_tick  = (req_r.kind == KIND_TICK);
  assign is_read  = (req_r.kind == KIND_READ);
  assign is_write = (req_r.kind == KIND_WRITE);

  always_comb begin
    ctrl_a         = '0;
    ctrl_b         = '0;
    ctrl_a.tick    = is_tick;
    ctrl_b.tick    = is_tick;
    ctrl_a.data    = req_r.write_data;
    ctrl_b.data    = req_r.write_data;
    ctrl_a.wr_lo   = is_write && (req_r.address == ADDR_TA_LO);
    ctrl_a.wr_hi   = is_write && (req_r.address == ADDR_TA_HI);
    ctrl_a.wr_ctrl = is_write && (req_r.address == ADDR_CRA);
    ctrl_a.wr_mask = is_write && (req_r.address == ADDR_ICR) && req_r.write_data[0];
    ctrl_b.wr_lo   = is_write && (req_r.address == ADDR_TB_LO);
    ctrl_b.wr_hi   = is_write && (req_r.address == ADDR_TB_HI);
    ctrl_b.wr_ctrl = is_write && (req_r.address == ADDR_CRB);
    ctrl_b.wr_mask = is_write && (req_r.address == ADDR_ICR) && req_r.write_data[1];
  end

  cia_timer u_timer_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .ctrl   (ctrl_a),
    .fire   (fire_a)
  );

  cia_timer u_timer_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .ctrl   (ctrl_b),
    .fire   (fire_b)
  );

  // read data, flags and interrupt line
  always_comb begin
    flags_nxt = flags_r;
    irq_nxt   = irq_r;
    rd_nxt    = 8'h00;
    if (is_tick) begin
      flags_nxt = flags_r | {fire_b, fire_a};
      irq_nxt   = irq_r | fire_a | fire_b;
    end else if (is_read) begin
      priority if (req_r.address == ADDR_ICR) begin
        rd_nxt    = ICR_READ_TAG | {6'd0, flags_r};
        flags_nxt = 2'b00;
        irq_nxt   = 1'b0;
      end else if (req_r.address == ADDR_KEY_ROW) begin
        rd_nxt = req_r.key_rows;
      end else begin
        rd_nxt = reg_file_r[req_r.address];
      end
    end
  end

  // keyboard column after this request
  assign key_col_nxt = (is_write && (req_r.address == ADDR_KEY_COL)) ?
                       req_r.write_data : reg_file_r[ADDR_KEY_COL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= 2'b00;
      irq_r   <= 1'b0;
      for (int i = 0; i < REG_DEPTH; i++) begin
        reg_file_r[i] <= 8'h00;
      end
    end else if (advance) begin
      flags_r <= flags_nxt;
      irq_r   <= irq_nxt;
      if (is_write) begin
        reg_file_r[req_r.address] <= req_r.write_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.read_data  <= rd_nxt;
      out_r.irq_line   <= irq_nxt;
      out_r.key_column <= key_col_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the dual timer interrupt block: a directed table of
// register and timer requests, then ~1400 biased random requests under three
// idle patterns, each response checked against its table row or a local behavioral model
// ----------------------------------------------------------------------------
module tb_top;
  import cia_pkg::*;

  // request kind that the block must ignore
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PER_PH = 475;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned DRAIN_CYCLES  = 8;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t rsp;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  // model state of the timers, interrupt logic and register file
  logic [15:0] tmr_latch [2] = '{16'h0, 16'h0};
  logic [15:0] tmr_count [2] = '{16'h0, 16'h0};
  logic        tmr_run   [2] = '{1'b0, 1'b0};
  logic        tmr_cont  [2] = '{1'b0, 1'b0};
  logic        tmr_mask  [2] = '{1'b0, 1'b0};
  logic [1:0]  irq_flags = 2'b00;
  logic        irq_out   = 1'b0;
  logic [7:0]  shadow_regs [REG_DEPTH];

  out_item_t   expected_responses [$];
  dir_row_t    offered_requests [$];
  dir_row_t    dir_rows [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned tx_pct [3] = '{15, 84, 0};
  int unsigned rx_pct [3] = '{84, 15, 0};
  bit          long_hold_req = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  cia_dual_timer_interrupt_block i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  initial begin
    foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
  end

  // next response of the block for one request, advancing the model state
  function automatic out_item_t predict_response(in_item_t req);
    out_item_t rsp;
    int        idx;
    rsp = '0;
    case (req.kind)
      KIND_TICK: begin
        for (int t = 0; t < 2; t++) begin
          if (tmr_run[t]) begin
            tmr_count[t] = tmr_count[t] - 16'd1;
            // underflow only counts when the interrupt is unmasked
            if (tmr_mask[t] && tmr_count[t] == 16'h0000) begin
              irq_flags[t] = 1'b1;
              irq_out      = 1'b1;
              if (tmr_cont[t]) tmr_count[t] = tmr_latch[t];
              else tmr_run[t] = 1'b0;
            end
          end
        end
      end
      KIND_READ: begin
        if (req.address == ADDR_ICR) begin
          rsp.read_data = ICR_READ_TAG | {6'b0, irq_flags};
          irq_flags     = 2'b00;
          irq_out       = 1'b0;
        end else if (req.address == ADDR_KEY_ROW) begin
          rsp.read_data = req.key_rows;
        end else begin
          rsp.read_data = shadow_regs[req.address];
        end
      end
      KIND_WRITE: begin
        // address bit 1 picks timer b for latch accesses; control accesses pick it by address
        idx = int'(req.address[1]);
        case (req.address)
          ADDR_ICR: begin
            if (req.write_data[0]) tmr_mask[0] = req.write_data[ICR_SET_CLR];
            if (req.write_data[1]) tmr_mask[1] = req.write_data[ICR_SET_CLR];
          end
          ADDR_TA_LO, ADDR_TB_LO: tmr_latch[idx][7:0]  = req.write_data;
          ADDR_TA_HI, ADDR_TB_HI: tmr_latch[idx][15:8] = req.write_data;
          ADDR_CRA, ADDR_CRB: begin
            idx = int'(req.address == ADDR_CRB);
            tmr_run[idx]  = req.write_data[CR_START];
            tmr_cont[idx] = !req.write_data[CR_ONESHOT];
            if (req.write_data[CR_LOAD]) tmr_count[idx] = tmr_latch[idx];
          end
          default: ;
        endcase
        shadow_regs[req.address] = req.write_data;
      end
      default: ;
    endcase
    rsp.irq_line   = irq_out;
    rsp.key_column = shadow_regs[ADDR_KEY_COL];
    return rsp;
  endfunction

  function automatic dir_row_t row(logic [1:0] kind, logic [3:0] addr, logic [7:0] data,
                                   logic [7:0] rows, logic typed, logic [7:0] rd,
                                   logic irq, logic [7:0] col);
    dir_row_t r;
    r.req.kind       = kind;
    r.req.address    = addr;
    r.req.write_data = data;
    r.req.key_rows   = rows;
    r.typed          = typed;
    r.rsp.read_data  = rd;
    r.rsp.irq_line   = irq;
    r.rsp.key_column = col;
    return r;
  endfunction

  // biased random request: small latches and frequent loads keep timers firing
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned roll;
    int unsigned sub;
    req.kind       = KIND_TICK;
    req.address    = 4'($urandom_range(15));
    req.write_data = 8'($urandom_range(255));
    req.key_rows   = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 45) begin
      req.kind = KIND_TICK;
    end else if (roll < 65) begin
      req.kind = KIND_READ;
      if ($urandom_range(99) < 30) req.address = ADDR_ICR;
    end else if (roll < 95) begin
      req.kind = KIND_WRITE;
      sub = $urandom_range(9);
      case (sub)
        0, 1: begin
          req.address = $urandom_range(1) ? ADDR_TB_LO : ADDR_TA_LO;
          if ($urandom_range(99) < 85) req.write_data = 8'($urandom_range(12, 1));
        end
        2: begin
          req.address = $urandom_range(1) ? ADDR_TB_HI : ADDR_TA_HI;
          if ($urandom_range(99) < 80) req.write_data = 8'h00;
        end
        3, 4: begin
          req.address = $urandom_range(1) ? ADDR_CRB : ADDR_CRA;
          req.write_data[CR_START] = ($urandom_range(99) < 80);
          req.write_data[CR_LOAD]  = ($urandom_range(99) < 70);
        end
        5: begin
          req.address = ADDR_ICR;
          req.write_data[ICR_SET_CLR] = ($urandom_range(99) < 75);
        end
        6: req.address = ADDR_KEY_COL;
        default: ;
      endcase
    end else begin
      req.kind = KIND_NONE;
    end
    return req;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic offer_request(dir_row_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offered_requests.push_back(r);
    in_valid <= 1'b1;
    in_data  <= r.req;
    do @(posedge clk); while (!in_ready);
  endtask

  // response side: random stalls plus one long hold per random phase
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // check responses and predict accepted requests
  always @(posedge clk) begin
    dir_row_t  r;
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_responses.size() == 0) begin
          $error("response with no request pending: %h", out_data);
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
            mismatches++;
          end
          if (out_data.irq_line !== want.irq_line) begin
            $error("irq_line: expected %b, got %b", want.irq_line, out_data.irq_line);
            mismatches++;
          end
          if (out_data.key_column !== want.key_column) begin
            $error("key_column: expected %h, got %h", want.key_column, out_data.key_column);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r    = offered_requests.pop_front();
        want = predict_response(in_data);
        if (r.typed) want = r.rsp;
        expected_responses.push_back(want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    // after reset, extremes, ignored kind, then a/b timer scenarios
    dir_rows.push_back(row(KIND_READ,  ADDR_ICR,     8'h00, 8'h00, 1'b1, 8'h80, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_READ,  ADDR_KEY_ROW, 8'h00, 8'hFF, 1'b1, 8'hFF, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_READ,  ADDR_KEY_ROW, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_READ,  ADDR_TA_HI,   8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_KEY_COL, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b0, 8'hFF));
    dir_rows.push_back(row(KIND_NONE,  4'hF,         8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 8'hFF));
    dir_rows.push_back(row(KIND_WRITE, ADDR_KEY_COL, 8'h00, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00));
    // timer a: latch 3, unmasked, continuous, forced load
    dir_rows.push_back(row(KIND_WRITE, ADDR_TA_LO,   8'h03, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_TA_HI,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_ICR,     8'h81, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_CRA,     8'h11, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    repeat (3)
      dir_rows.push_back(row(KIND_TICK, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_READ,  ADDR_CRA,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_READ,  ADDR_ICR,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    // timer b: latch 1, one-shot, stops after its underflow
    dir_rows.push_back(row(KIND_WRITE, ADDR_TB_LO,   8'h01, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_TB_HI,   8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_ICR,     8'h82, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_CRB,     8'h19, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    repeat (2)
      dir_rows.push_back(row(KIND_TICK, 4'h0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    // mask both timers, then full-scale latch loaded without start
    dir_rows.push_back(row(KIND_WRITE, ADDR_ICR,     8'h03, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_TA_HI,   8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_TA_LO,   8'hFF, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_WRITE, ADDR_CRA,     8'h10, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));
    dir_rows.push_back(row(KIND_READ,  ADDR_ICR,     8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    foreach (dir_rows[i]) offer_request(dir_rows[i]);

    // random phases, each starting with a long response hold
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct   = tx_pct[ph];
      rx_idle_pct   = rx_pct[ph];
      long_hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PH; n++) begin
        r       = '0;
        r.req   = random_request();
        r.typed = 1'b0;
        offer_request(r);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_responses.size() != 0) begin
      $error("%0d responses never arrived", expected_responses.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
